/* hw/rtl/wsd_pkg.sv */
`default_nettype none

package wsd_pkg;

  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 8;
  localparam int STD_W    = 16;

  typedef enum logic [6:0] {
    ST_ACC   = 7'b0000001,
    ST_DRAIN = 7'b0000010,
    ST_MUL_A = 7'b0000100,
    ST_MUL_B = 7'b0001000,
    ST_SQRT  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_LOAD  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic take;
    logic mul_a_init;
    logic mul_b_init;
    logic mul_step;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic mul_done;
    logic root_done;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/wsd_in_if.sv */
`default_nettype none

interface wsd_in_if;
  logic                           valid;
  logic                           ready;
  logic [wsd_pkg::VALUE_W-1:0]    sample_value;
  logic [wsd_pkg::WEIGHT_W-1:0]   sample_weight;
  logic                           last_item;

  modport source (output valid, output sample_value, output sample_weight,
                  output last_item, input ready);
  modport sink (input valid, input sample_value, input sample_weight,
                input last_item, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wsd_out_if.sv */
`default_nettype none

interface wsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [wsd_pkg::STD_W-1:0]   std_dev;
  logic                        zero_weight;
  logic                        too_many;

  modport source (output valid, output std_dev, output zero_weight,
                  output too_many, input ready);
  modport sink (input valid, input std_dev, input zero_weight,
                input too_many, output ready);
endinterface

`default_nettype wire

/* hw/rtl/weighted_standard_deviation_unit.sv */
`default_nettype none

// Weighted population standard deviation of a stream of (value, weight, last)
// items; values are signed Q8.8, weights unsigned integers. While a data set
// streams in, one item is taken every cycle, also while an earlier result still
// waits at the output register. The item marked last closes the set: input then
// stalls while the sums drain and one shared bit-serial datapath computes W*Sxx
// and Sx^2 with two shift-add multiplies, the integer square root of their
// difference and its division by W, one bit per cycle each. The result is loaded
// once the output register is free, and the next set may start right after.
// std_dev is floor(sqrt(W*Sxx - Sx^2) / W) in Q8.8; zero_weight marks a set
// whose weights summed to zero (std_dev then 0), too_many marks a set that had
// items beyond MAX_ITEMS, which were dropped.
module weighted_standard_deviation_unit #(
  parameter int MAX_ITEMS   = 1024,
  parameter int VALUE_BITS  = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  wsd_in_if.sink        in_ch,
  wsd_out_if.source     out_ch
);

  wsd_pkg::cmd_t cmd;
  wsd_pkg::sts_t sts;

  wsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_item),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsd_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_BITS  (VALUE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample_value  (in_ch.sample_value),
    .in_sample_weight (in_ch.sample_weight),
    .cmd              (cmd),
    .sts              (sts),
    .out_std_dev      (out_ch.std_dev),
    .out_zero_weight  (out_ch.zero_weight),
    .out_too_many     (out_ch.too_many)
  );

endmodule

`default_nettype wire

/* hw/rtl/wsd_ctrl.sv */
`default_nettype none

module wsd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire wsd_pkg::sts_t  sts,
  output wsd_pkg::cmd_t       cmd
);

  wsd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      wsd_pkg::ST_ACC: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = wsd_pkg::ST_DRAIN;
        end
      end
      wsd_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.mul_a_init = 1'b1;
          state_nxt      = wsd_pkg::ST_MUL_A;
        end
      end
      wsd_pkg::ST_MUL_A: begin
        if (sts.mul_done) begin
          cmd.mul_b_init = 1'b1;
          state_nxt      = wsd_pkg::ST_MUL_B;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      wsd_pkg::ST_MUL_B: begin
        if (sts.mul_done) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = wsd_pkg::ST_SQRT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      wsd_pkg::ST_SQRT: begin
        if (sts.root_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = wsd_pkg::ST_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      wsd_pkg::ST_DIV: begin
        if (sts.root_done) begin
          state_nxt = wsd_pkg::ST_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      wsd_pkg::ST_LOAD: begin
        // wait until the output register is free or drains this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = wsd_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = wsd_pkg::ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsd_pkg::ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && in_last) |=> !in_ready)
    else $error("input taken right after the last item of a data set");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wsd_pkg::ST_LOAD))
    else $error("result raised outside the load state");
`endif

endmodule

`default_nettype wire

/* hw/rtl/wsd_dp.sv */
`default_nettype none

module wsd_dp #(
  parameter int MAX_ITEMS   = 1024,
  parameter int VALUE_BITS  = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [wsd_pkg::VALUE_W-1:0]    in_sample_value,
  input  wire logic [wsd_pkg::WEIGHT_W-1:0]   in_sample_weight,
  input  wire wsd_pkg::cmd_t                  cmd,
  output wsd_pkg::sts_t                       sts,
  output logic [wsd_pkg::STD_W-1:0]           out_std_dev,
  output logic                                out_zero_weight,
  output logic                                out_too_many
);

  localparam int LOG_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int W_W    = WEIGHT_BITS + LOG_W;
  localparam int SX_W   = VALUE_BITS + WEIGHT_BITS + LOG_W;
  localparam int SXX_W  = 2 * VALUE_BITS + WEIGHT_BITS + LOG_W - 1;
  localparam int PA_W   = VALUE_BITS + WEIGHT_BITS;
  localparam int SQ_W   = 2 * VALUE_BITS;
  localparam int PB_W   = SQ_W + WEIGHT_BITS;
  localparam int A_W    = W_W + SXX_W;
  localparam int B_W    = 2 * SX_W;
  localparam int DW0    = (A_W > B_W) ? A_W : B_W;
  localparam int DW     = DW0 + (DW0 % 2);
  localparam int RW     = DW / 2;
  localparam int MP_W   = (SX_W > W_W) ? SX_W : W_W;
  localparam int SR_W   = RW + 2;
  localparam int IT_MAX = (MP_W > RW) ? MP_W : RW;
  localparam int IT_W   = $clog2(IT_MAX + 1);
  localparam int STD_W  = wsd_pkg::STD_W;
  localparam int QX_W   = (RW > STD_W) ? RW : STD_W + 1;

  // accumulation pipeline
  logic                          va_r, vb_r;
  logic [CNT_W-1:0]              items_r;
  logic                          ovf_r;
  logic signed [PA_W-1:0]        pa_r, pa_nxt;
  logic [SQ_W-1:0]               sq_r, sq_nxt;
  logic [WEIGHT_BITS-1:0]        wa_r;
  logic [PB_W-1:0]               pb_r, pb_nxt;
  logic [W_W-1:0]                wsum_r;
  logic signed [SX_W-1:0]        sx_r;
  logic [SXX_W-1:0]              sxx_r;

  logic [VALUE_BITS-1:0]         raw_in, mag_in;
  logic signed [VALUE_BITS-1:0]  v_in;
  logic [WEIGHT_BITS-1:0]        w_in;
  logic                          keep;

  // final computation
  logic [DW-1:0]                 acc_r, cand_r, a_r, d_r;
  logic [MP_W-1:0]               plier_r;
  logic [SX_W-1:0]               sx_u, ax;
  logic [RW-1:0]                 root_r, q_r;
  logic [SR_W-1:0]               srem_r;
  logic [SR_W:0]                 rem_sh, trial, s_diff;
  logic                          s_ge;
  logic [W_W-1:0]                drem_r;
  logic [W_W:0]                  r_sh, w_ext, r_diff;
  logic                          d_ge;
  logic [IT_W-1:0]               it_r;
  logic [QX_W-1:0]               q_ext;
  logic [STD_W-1:0]              std_nxt;

  assign raw_in = in_sample_value[VALUE_BITS-1:0];
  assign v_in   = $signed(raw_in);
  assign w_in   = in_sample_weight[WEIGHT_BITS-1:0];
  assign mag_in = raw_in[VALUE_BITS-1] ? (~raw_in + 1'b1) : raw_in;
  assign keep   = cmd.take && (items_r < CNT_W'(MAX_ITEMS));

  assign pa_nxt = PA_W'(v_in) * $signed({{VALUE_BITS{1'b0}}, w_in});
  assign sq_nxt = SQ_W'(mag_in) * SQ_W'(mag_in);
  assign pb_nxt = PB_W'(sq_r) * PB_W'(wa_r);

  assign sx_u = sx_r;
  assign ax   = sx_u[SX_W-1] ? (~sx_u + 1'b1) : sx_u;

  // one root bit per step, restoring
  assign rem_sh = {srem_r[SR_W-2:0], d_r[DW-1:DW-2]};
  assign trial  = (SR_W + 1)'({root_r, 2'b01});
  assign s_ge   = rem_sh >= trial;
  assign s_diff = rem_sh - trial;

  // one quotient bit per step, restoring
  assign r_sh   = {drem_r, q_r[RW-1]};
  assign w_ext  = (W_W + 1)'(wsum_r);
  assign d_ge   = r_sh >= w_ext;
  assign r_diff = r_sh - w_ext;

  assign q_ext   = QX_W'(q_r);
  assign std_nxt = (wsum_r == '0) ? '0 :
                   (|q_ext[QX_W-1:STD_W]) ? {STD_W{1'b1}} : q_ext[STD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      items_r <= '0;
      ovf_r   <= 1'b0;
      wsum_r  <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
    end else if (cmd.load) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      items_r <= '0;
      ovf_r   <= 1'b0;
      wsum_r  <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
    end else begin
      va_r <= keep;
      vb_r <= va_r;
      if (keep) begin
        items_r <= items_r + 1'b1;
      end
      if (cmd.take && !keep) begin
        ovf_r <= 1'b1;
      end
      if (va_r) begin
        wsum_r <= wsum_r + W_W'(wa_r);
        sx_r   <= sx_r + SX_W'(pa_r);
      end
      if (vb_r) begin
        sxx_r <= sxx_r + SXX_W'(pb_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      pa_r <= pa_nxt;
      sq_r <= sq_nxt;
      wa_r <= w_in;
    end
    if (va_r) begin
      pb_r <= pb_nxt;
    end

    if (cmd.mul_a_init || cmd.mul_b_init || cmd.sqrt_init || cmd.div_init) begin
      it_r <= '0;
    end else if (cmd.mul_step || cmd.sqrt_step || cmd.div_step) begin
      it_r <= it_r + 1'b1;
    end

    if (cmd.mul_a_init) begin
      acc_r   <= '0;
      cand_r  <= DW'(sxx_r);
      plier_r <= MP_W'(wsum_r);
    end else if (cmd.mul_b_init) begin
      a_r     <= acc_r;
      acc_r   <= '0;
      cand_r  <= DW'(ax);
      plier_r <= MP_W'(ax);
    end else if (cmd.mul_step) begin
      if (plier_r[0]) begin
        acc_r <= acc_r + cand_r;
      end
      cand_r  <= cand_r << 1;
      plier_r <= plier_r >> 1;
    end

    if (cmd.sqrt_init) begin
      d_r    <= (a_r >= acc_r) ? (a_r - acc_r) : '0;
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      d_r    <= d_r << 2;
      root_r <= {root_r[RW-2:0], s_ge};
      srem_r <= s_ge ? SR_W'(s_diff) : SR_W'(rem_sh);
    end

    if (cmd.div_init) begin
      q_r    <= root_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[RW-2:0], d_ge};
      drem_r <= d_ge ? W_W'(r_diff) : W_W'(r_sh);
    end

    if (cmd.load) begin
      out_std_dev     <= std_nxt;
      out_zero_weight <= (wsum_r == '0);
      out_too_many    <= ovf_r;
    end
  end

  assign sts.pipe_empty = !va_r && !vb_r;
  assign sts.mul_done   = (it_r == IT_W'(MP_W));
  assign sts.root_done  = (it_r == IT_W'(RW));

`ifndef ASSERT_OFF
  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond its limit");

  a_drained_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_a_init |-> (!va_r && !vb_r))
    else $error("final computation started with sums still in flight");

  a_zero_weight_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (wsum_r == '0) |-> ((sx_r == '0) && (sxx_r == '0)))
    else $error("nonzero moment sums under a zero weight sum");
`endif

endmodule

`default_nettype wire
